@@ design/adaptive_morse_tone_decoder_defines.svh @@
`ifndef ADAPTIVE_MORSE_TONE_DECODER_DEFINES_SVH
`define ADAPTIVE_MORSE_TONE_DECODER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AMTD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AMTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/amtd_pkg.sv @@
package amtd_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_RUN_BITS    = 24;

   // Fixed field and state widths
   localparam int MAX_ELEMENTS = 8;
   localparam int PATTERN_W    = 8;
   localparam int COUNT_W      = 4;
   localparam int LEN_W        = $clog2(MAX_ELEMENTS + 2);
   localparam int LEVEL_W      = 32;
   localparam int DOT_W        = 24;
   localparam int ALPHA_W      = 16;
   localparam int DECAY_W      = 24;
   localparam int INIT_DOT_W   = 16;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_ENV_ALPHA  = 2'd0;
   localparam logic [1:0] CSR_PEAK_DECAY = 2'd1;
   localparam logic [1:0] CSR_INIT_DOT   = 2'd2;

   localparam logic [ALPHA_W-1:0]    ENV_ALPHA_RESET  = 16'd272;
   localparam logic [DECAY_W-1:0]    PEAK_DECAY_RESET = 24'd16777041;
   localparam logic [INIT_DOT_W-1:0] INIT_DOT_RESET   = 16'd2880;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;
   localparam logic KIND_LETTER = 1'b0;
   localparam logic KIND_GAP    = 1'b1;

   // Exact floor division for x < 2^27 (by 5) and x < 2^28 (by 15)
   localparam logic [27:0] RECIP5  = 28'd214748365;
   localparam logic [28:0] RECIP15 = 29'd286331154;

   typedef struct packed {
      logic                 kind;
      logic [COUNT_W-1:0]   count;
      logic [PATTERN_W-1:0] pattern;
      logic                 too_long;
      logic                 last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_pair_type;

   typedef struct packed {
      logic                  en;
      logic [INIT_DOT_W-1:0] value;
   } dot_load_type;

endpackage

@@ design/amtd_envelope.sv @@
module amtd_envelope #(
   parameter int SAMPLE_BITS = amtd_pkg::DEF_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               update,
   input  logic signed [SAMPLE_BITS-1:0]      sample,
   input  logic [amtd_pkg::ALPHA_W-1:0]       alpha,
   input  logic [amtd_pkg::DECAY_W-1:0]       decay,
   output logic [amtd_pkg::LEVEL_W-1:0]       env,
   output logic [amtd_pkg::LEVEL_W-1:0]       peak
);
   import amtd_pkg::*;

   logic [LEVEL_W-1:0]         env_ff, env_in;
   logic [LEVEL_W-1:0]         peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0]     raw;
   logic [SAMPLE_BITS-1:0]     mag;
   logic [LEVEL_W-1:0]         mag_level;
   logic                       rising;
   logic [LEVEL_W-1:0]         diff;
   logic [LEVEL_W+ALPHA_W-1:0] env_prod;
   logic [LEVEL_W-1:0]         env_step;
   logic [LEVEL_W-1:0]         env_new;
   logic [LEVEL_W+DECAY_W-1:0] peak_prod;

   always_comb begin
      raw       = $unsigned(sample);
      // most negative sample maps to 2^(bits-1), which still fits
      mag       = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
      mag_level = LEVEL_W'(mag) << (LEVEL_W - SAMPLE_BITS);
      rising    = mag_level >= env_ff;
      diff      = rising ? (mag_level - env_ff) : (env_ff - mag_level);
      env_prod  = (LEVEL_W+ALPHA_W)'(diff) * (LEVEL_W+ALPHA_W)'(alpha);
      env_step  = env_prod[LEVEL_W+ALPHA_W-1:ALPHA_W];
      env_new   = rising ? (env_ff + env_step) : (env_ff - env_step);
      peak_prod = (LEVEL_W+DECAY_W)'(peak_ff) * (LEVEL_W+DECAY_W)'(decay);
      env_in    = env_ff;
      peak_in   = peak_ff;
      if (update) begin
         env_in  = env_new;
         peak_in = (env_new > peak_ff) ? env_new : peak_prod[LEVEL_W+DECAY_W-1:DECAY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff  <= '0;
         peak_ff <= '0;
      end else begin
         env_ff  <= env_in;
         peak_ff <= peak_in;
      end
   end

   assign env  = env_ff;
   assign peak = peak_ff;

endmodule

@@ design/amtd_symbol.sv @@
module amtd_symbol #(
   parameter int RUN_BITS = amtd_pkg::DEF_RUN_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  amtd_pkg::dot_load_type        dot_load,
   input  logic                          fire,
   input  logic                          flush,
   input  logic [amtd_pkg::LEVEL_W-1:0]  env,
   input  logic [amtd_pkg::LEVEL_W-1:0]  peak,
   output amtd_pkg::rsp_pair_type        res
);
   import amtd_pkg::*;

   localparam int CW = (RUN_BITS + 12 > 30) ? RUN_BITS + 12 : 30;
   localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
   localparam logic [DOT_W-1:0]    DOT_MAX = '1;

   logic                 key_ff, key_in;
   logic [RUN_BITS-1:0]  run_ff, run_in;
   logic [DOT_W-1:0]     dot_ff, dot_in;
   logic [PATTERN_W-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 gap_ff, gap_in;
   logic                 text_ff, text_in;

   logic [LEVEL_W+4:0]   env20, peak11, peak7;
   logic                 new_key, change, end_run;
   logic [CW-1:0]        run_d, dot_w, dot2, dot3, dot5, dot10, d10;
   logic [CW-1:0]        x_dot, x_dash;
   logic [54:0]          prod_dot;
   logic [56:0]          prod_dash;
   logic                 glitch, mark_ev, space_ev, is_dash;
   logic [DOT_W-1:0]     dot_avg;
   logic [PATTERN_W-1:0] bits_a;
   logic [LEN_W-1:0]     len_a;
   logic [RUN_BITS-1:0]  run_inc;
   logic                 silence, end_word, end_let;
   logic                 letter_out, gap_out, text_a, gap_a;
   rsp_item_type         letter_item, gap_item;

   always_comb begin
      // hysteresis: down above 11/20 of peak, up below 7/20
      env20   = ((LEVEL_W+5)'(env) << 4) + ((LEVEL_W+5)'(env) << 2);
      peak11  = ((LEVEL_W+5)'(peak) << 3) + ((LEVEL_W+5)'(peak) << 1) + (LEVEL_W+5)'(peak);
      peak7   = ((LEVEL_W+5)'(peak) << 3) - (LEVEL_W+5)'(peak);
      new_key = key_ff ? !(env20 < peak7) : (env20 > peak11);
      change  = !flush && (new_key != key_ff);
      end_run = flush ? key_ff : change;

      run_d = CW'(run_ff) << 8;
      dot_w = CW'(dot_ff);
      dot2  = dot_w << 1;
      dot3  = dot2 + dot_w;
      dot5  = (dot_w << 2) + dot_w;
      dot10 = dot5 << 1;
      d10   = (run_d << 3) + (run_d << 1);

      glitch   = d10 < dot3;
      mark_ev  = end_run && !glitch && key_ff;
      space_ev = end_run && !glitch && !key_ff;
      is_dash  = run_d >= dot2;

      // weighted dot update, divided by reciprocal multiply
      x_dot     = (dot_w << 2) + run_d;
      x_dash    = (dot_w << 3) + (dot_w << 2) + run_d;
      prod_dot  = 55'(x_dot[26:0]) * 55'(RECIP5);
      prod_dash = 57'(x_dash[27:0]) * 57'(RECIP15);
      if (is_dash) begin
         dot_avg = (x_dash >= (CW'(15) << DOT_W)) ? DOT_MAX : prod_dash[55:32];
      end else begin
         dot_avg = (x_dot >= (CW'(5) << DOT_W)) ? DOT_MAX : prod_dot[53:30];
      end

      bits_a = bits_ff;
      len_a  = len_ff;
      if (mark_ev) begin
         if (len_ff < LEN_W'(MAX_ELEMENTS)) begin
            bits_a = bits_ff | (PATTERN_W'(is_dash) << len_ff);
         end
         if (len_ff <= LEN_W'(MAX_ELEMENTS)) begin
            len_a = len_ff + 1'b1;
         end
      end

      run_inc = (run_ff == RUN_MAX) ? run_ff : run_ff + 1'b1;
      silence = !flush && !change && !key_ff && ((CW'(run_inc) << 8) > dot10);

      end_word   = (space_ev && (run_d > dot5)) || silence;
      end_let    = end_word || (space_ev && (run_d > dot2)) || flush;
      letter_out = end_let && (len_a != '0);
      text_a     = text_ff || letter_out;
      gap_a      = mark_ev ? 1'b0 : gap_ff;
      gap_out    = end_word && !gap_a && text_a;

      letter_item.kind     = KIND_LETTER;
      letter_item.count    = (len_a > LEN_W'(MAX_ELEMENTS)) ? COUNT_W'(MAX_ELEMENTS)
                                                             : COUNT_W'(len_a);
      letter_item.pattern  = bits_a;
      letter_item.too_long = len_a > LEN_W'(MAX_ELEMENTS);
      letter_item.last     = !gap_out;

      gap_item.kind     = KIND_GAP;
      gap_item.count    = '0;
      gap_item.pattern  = '0;
      gap_item.too_long = 1'b0;
      gap_item.last     = 1'b1;

      res.num    = {1'b0, letter_out} + {1'b0, gap_out};
      res.first  = letter_out ? letter_item : gap_item;
      res.second = gap_item;
   end

   always_comb begin
      key_in  = key_ff;
      run_in  = run_ff;
      dot_in  = dot_ff;
      bits_in = bits_ff;
      len_in  = len_ff;
      gap_in  = gap_ff;
      text_in = text_ff;
      if (dot_load.en) begin
         dot_in = {dot_load.value, 8'b0};
      end else if (fire && mark_ev) begin
         dot_in = dot_avg;
      end
      if (fire) begin
         key_in  = flush ? 1'b0 : new_key;
         run_in  = end_run ? '0 : (flush ? run_ff : run_inc);
         bits_in = letter_out ? '0 : bits_a;
         len_in  = letter_out ? '0 : len_a;
         gap_in  = gap_a || gap_out;
         text_in = text_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= 1'b0;
         run_ff  <= '0;
         dot_ff  <= {INIT_DOT_RESET, 8'b0};
         bits_ff <= '0;
         len_ff  <= '0;
         gap_ff  <= 1'b0;
         text_ff <= 1'b0;
      end else begin
         key_ff  <= key_in;
         run_ff  <= run_in;
         dot_ff  <= dot_in;
         bits_ff <= bits_in;
         len_ff  <= len_in;
         gap_ff  <= gap_in;
         text_ff <= text_in;
      end
   end

endmodule

@@ design/adaptive_morse_tone_decoder.sv @@
// Channel   Dir  Handshake          Payload
// req_      in   tvalid/tready      tuser = kind, tdata = sample
// rsp_      out  tvalid/tready      tuser = result_kind, tlast = last,
//                                   tdata = element_count, pattern, too_long
// csr_      in   psel/penable       three registers at byte offsets 0, 4, 8
//
// One sample or flush is taken per cycle unless the result queue holds the symbol stage.
// The envelope multipliers and the symbol stage each close their state loop without an added register.
// An item giving two results needs two result transfers; a four-entry result queue
// absorbs them, and the symbol stage holds while fewer than two entries are free.
// Synchronous reset leaves no clearing pass.
`include "adaptive_morse_tone_decoder_defines.svh"

module adaptive_morse_tone_decoder #(
   parameter int SAMPLE_BITS = amtd_pkg::DEF_SAMPLE_BITS,
   parameter int RUN_BITS    = amtd_pkg::DEF_RUN_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                                req_tuser,   // [0] kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [3:0] element_count,
                                                            // [11:4] pattern, [12] too_long
   output logic                                rsp_tuser,   // [0] result_kind
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [amtd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [amtd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [amtd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import amtd_pkg::*;

   localparam int Q_DEPTH = 4;
   localparam int PTR_W   = $clog2(Q_DEPTH);
   localparam int CNT_W   = $clog2(Q_DEPTH + 1);

   logic [ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic [DECAY_W-1:0]    decay_ff, decay_in;
   logic [INIT_DOT_W-1:0] init_dot_ff, init_dot_in;

   logic                          r_vld_ff, r_vld_in;
   logic                          r_kind_ff, r_kind_in;
   logic signed [SAMPLE_BITS-1:0] r_sample_ff, r_sample_in;
   logic                          s1_vld_ff, s1_vld_in;
   logic                          s1_kind_ff, s1_kind_in;

   rsp_item_type       q_ff [Q_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   q_cnt_ff, q_cnt_in;

   logic               req_take, fire, s1_adv, r_adv, pop;
   logic [1:0]         push;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   logic [LEVEL_W-1:0] env, peak;
   dot_load_type       dot_load;
   rsp_pair_type       res;
   rsp_item_type       head;

   // Configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      alpha_in    = alpha_ff;
      decay_in    = decay_ff;
      init_dot_in = init_dot_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_ENV_ALPHA:  alpha_in    = csr_pwdata[ALPHA_W-1:0];
            CSR_PEAK_DECAY: decay_in    = csr_pwdata[DECAY_W-1:0];
            CSR_INIT_DOT:   init_dot_in = csr_pwdata[INIT_DOT_W-1:0];
            default:        ;
         endcase
      end
      dot_load.en    = csr_wr && (csr_idx == CSR_INIT_DOT);
      dot_load.value = csr_pwdata[INIT_DOT_W-1:0];
   end

   always_comb begin
      case (csr_idx)
         CSR_ENV_ALPHA:  csr_prdata = CSR_DATA_W'(alpha_ff);
         CSR_PEAK_DECAY: csr_prdata = CSR_DATA_W'(decay_ff);
         CSR_INIT_DOT:   csr_prdata = CSR_DATA_W'(init_dot_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Pipeline control: input register, envelope stage, symbol stage into the queue
   always_comb begin
      fire       = s1_vld_ff && (q_cnt_ff <= CNT_W'(Q_DEPTH - 2));
      s1_adv     = !s1_vld_ff || fire;
      r_adv      = r_vld_ff && s1_adv;
      req_tready = !r_vld_ff || s1_adv;
      req_take   = req_tvalid && req_tready;

      r_vld_in    = req_take ? 1'b1 : (r_adv ? 1'b0 : r_vld_ff);
      r_kind_in   = req_take ? req_tuser : r_kind_ff;
      r_sample_in = req_take ? $signed(req_tdata[SAMPLE_BITS-1:0]) : r_sample_ff;
      s1_vld_in   = r_adv ? 1'b1 : (fire ? 1'b0 : s1_vld_ff);
      s1_kind_in  = r_adv ? r_kind_ff : s1_kind_ff;
   end

   amtd_envelope #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_envelope (
      .clock  (clock),
      .reset  (reset),
      .update (r_adv && (r_kind_ff == KIND_SAMPLE)),
      .sample (r_sample_ff),
      .alpha  (alpha_ff),
      .decay  (decay_ff),
      .env    (env),
      .peak   (peak)
   );

   amtd_symbol #(
      .RUN_BITS (RUN_BITS)
   ) u_symbol (
      .clock    (clock),
      .reset    (reset),
      .dot_load (dot_load),
      .fire     (fire),
      .flush    (s1_kind_ff == KIND_FLUSH),
      .env      (env),
      .peak     (peak),
      .res      (res)
   );

   // Result queue
   always_comb begin
      push      = fire ? res.num : 2'd0;
      pop       = rsp_tvalid && rsp_tready;
      wr_ptr_in = wr_ptr_ff + PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      q_cnt_in  = q_cnt_ff + CNT_W'(push) - CNT_W'(pop);
      head      = q_ff[rd_ptr_ff];
   end

   assign rsp_tvalid = q_cnt_ff != '0;
   assign rsp_tdata  = {3'b0, head.too_long, head.pattern, head.count};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   always_ff @(posedge clock) begin
      if (push != 2'd0) begin
         q_ff[wr_ptr_ff] <= res.first;
      end
      if (push == 2'd2) begin
         q_ff[wr_ptr_ff + 1'b1] <= res.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ENV_ALPHA_RESET;
         decay_ff    <= PEAK_DECAY_RESET;
         init_dot_ff <= INIT_DOT_RESET;
         r_vld_ff    <= 1'b0;
         s1_vld_ff   <= 1'b0;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         q_cnt_ff    <= '0;
      end else begin
         alpha_ff    <= alpha_in;
         decay_ff    <= decay_in;
         init_dot_ff <= init_dot_in;
         r_vld_ff    <= r_vld_in;
         s1_vld_ff   <= s1_vld_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         q_cnt_ff    <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_kind_ff   <= r_kind_in;
      r_sample_ff <= r_sample_in;
      s1_kind_ff  <= s1_kind_in;
   end

   `AMTD_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_cnt_ff <= CNT_W'(Q_DEPTH), "result queue overflow")
   `AMTD_ASSERT_NOW(a_pair_order, clock, reset, fire && (res.num == 2'd2), (res.first.kind == KIND_LETTER) && (res.second.kind == KIND_GAP) && !res.first.last && res.second.last, "two results must be letter then word gap")
   `AMTD_ASSERT_NOW(a_flush_letter, clock, reset, fire && (s1_kind_ff == KIND_FLUSH), (res.num == 2'd0) || ((res.num == 2'd1) && (res.first.kind == KIND_LETTER)), "flush may close only a letter")
   `AMTD_ASSERT_NEXT(a_input_hold, clock, reset, r_vld_ff && !s1_adv, r_vld_ff && $stable(r_sample_ff) && $stable(r_kind_ff), "stalled input register lost its item")

endmodule

@@ verif/adaptive_morse_tone_decoder_test.sv @@
`timescale 1ns / 100ps

module adaptive_morse_tone_decoder_test;
   import amtd_pkg::*;

   localparam int SAMPLE_W = DEF_SAMPLE_BITS;
   localparam int RUN_W = DEF_RUN_BITS;
   localparam logic [RUN_W-1:0] RUN_LIMIT = '1;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 600;
   localparam int RANDOM_GOAL = 1100;

   typedef struct {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
   } audio_item_type;

   typedef struct {
      logic                 kind;
      logic [COUNT_W-1:0]   count;
      logic [PATTERN_W-1:0] pattern;
      logic                 too_long;
      logic                 last;
   } symbol_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   wire                     req_tready;
   logic [SAMPLE_W-1:0]     req_tdata = '0;     // [15:0] sample
   logic                    req_tuser = 1'b0;   // [0] kind
   wire                     rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   wire  [15:0]             rsp_tdata;          // [3:0] count, [11:4] pattern, [12] too_long
   wire                     rsp_tuser;          // [0] result_kind
   wire                     rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   wire  [CSR_DATA_W-1:0]   csr_prdata;
   wire                     csr_pready;

   adaptive_morse_tone_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Decoder state mirrored from the register, envelope and symbol logic
   logic [ALPHA_W-1:0]    alpha_cfg;
   logic [DECAY_W-1:0]    decay_cfg;
   logic [INIT_DOT_W-1:0] init_dot_cfg;
   logic [LEVEL_W-1:0]    env_lvl, peak_lvl;
   logic                  key_down;
   logic [RUN_W-1:0]      run_cnt;
   logic [DOT_W-1:0]      dot_est;
   logic [PATTERN_W-1:0]  sym_bits;
   logic [LEN_W-1:0]      sym_len;
   logic                  gap_sent, text_seen;

   audio_item_type audio_backlog[$];
   audio_item_type offered;
   symbol_type     expected_symbols[$];
   symbol_type     step_symbols[$];

   int  items_queued = 0;
   int  mismatches = 0;
   int  send_stall = 0;
   int  ready_stall = 0;
   bit  idle_en = 1'b1;
   bit  long_hold_request = 1'b0;

   function automatic void restart_decoder_state();
      alpha_cfg = ENV_ALPHA_RESET;
      decay_cfg = PEAK_DECAY_RESET;
      init_dot_cfg = INIT_DOT_RESET;
      env_lvl = '0;
      peak_lvl = '0;
      key_down = 1'b0;
      run_cnt = '0;
      dot_est = {INIT_DOT_RESET, 8'h00};
      sym_bits = '0;
      sym_len = '0;
      gap_sent = 1'b0;
      text_seen = 1'b0;
   endfunction

   function automatic void apply_setting(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_ENV_ALPHA:  alpha_cfg = value[ALPHA_W-1:0];
         CSR_PEAK_DECAY: decay_cfg = value[DECAY_W-1:0];
         CSR_INIT_DOT: begin
            init_dot_cfg = value[INIT_DOT_W-1:0];
            dot_est = {init_dot_cfg, 8'h00};
         end
         default: ;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] current_setting(logic [1:0] index);
      case (index)
         CSR_ENV_ALPHA:  return CSR_DATA_W'(alpha_cfg);
         CSR_PEAK_DECAY: return CSR_DATA_W'(decay_cfg);
         default:        return CSR_DATA_W'(init_dot_cfg);
      endcase
   endfunction

   function automatic void emit_symbol(logic kind, logic [COUNT_W-1:0] cnt,
                                       logic [PATTERN_W-1:0] pat, logic tl);
      step_symbols.push_back('{kind, cnt, pat, tl, 1'b0});
   endfunction

   function automatic void close_letter();
      if (sym_len != 0) begin
         emit_symbol(KIND_LETTER,
                     (sym_len > MAX_ELEMENTS) ? COUNT_W'(MAX_ELEMENTS) : COUNT_W'(sym_len),
                     sym_bits, sym_len > MAX_ELEMENTS);
         sym_bits = '0;
         sym_len = '0;
         text_seen = 1'b1;
      end
   endfunction

   function automatic void close_word();
      if (!gap_sent && text_seen) begin
         emit_symbol(KIND_GAP, '0, '0, 1'b0);
         gap_sent = 1'b1;
      end
   endfunction

   function automatic void add_element(logic dash);
      if (sym_len < MAX_ELEMENTS)
         sym_bits[sym_len] = dash;
      if (sym_len <= MAX_ELEMENTS)
         sym_len++;
   endfunction

   // Judge a finished mark or space against the dot estimate (Q16.8)
   function automatic void judge_run(logic was_mark, logic [RUN_W-1:0] run);
      logic [63:0] dur, dot, nd;
      dur = 64'(run) << 8;
      dot = 64'(dot_est);
      if (10 * dur < 3 * dot)
         return;
      if (was_mark) begin
         if (dur < 2 * dot) begin
            add_element(1'b0);
            nd = (4 * dot + dur) / 5;
         end else begin
            add_element(1'b1);
            nd = (12 * dot + dur) / 15;
         end
         dot_est = (nd > 64'hFF_FFFF) ? '1 : nd[DOT_W-1:0];
         gap_sent = 1'b0;
      end else if (dur > 5 * dot) begin
         close_letter();
         close_word();
      end else if (dur > 2 * dot) begin
         close_letter();
      end
   endfunction

   function automatic void decode_item(audio_item_type item);
      logic [SAMPLE_W:0] mag;
      logic [63:0]       target, level, prod;
      logic              next_key;
      step_symbols.delete();
      if (item.kind == KIND_FLUSH) begin
         if (key_down) begin
            judge_run(1'b1, run_cnt);
            key_down = 1'b0;
            run_cnt = '0;
         end
         close_letter();
      end else begin
         mag = item.sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - item.sample
                                       : (SAMPLE_W+1)'(item.sample);
         target = 64'(mag) << (LEVEL_W - SAMPLE_W);
         level = 64'(env_lvl);
         if (target >= level)
            level = level + (((target - level) * alpha_cfg) >> ALPHA_W);
         else
            level = level - (((level - target) * alpha_cfg) >> ALPHA_W);
         env_lvl = level[LEVEL_W-1:0];
         if (env_lvl > peak_lvl) begin
            peak_lvl = env_lvl;
         end else begin
            prod = (64'(peak_lvl) * decay_cfg) >> DECAY_W;
            peak_lvl = prod[LEVEL_W-1:0];
         end
         next_key = key_down;
         if (!key_down && 20 * 64'(env_lvl) > 11 * 64'(peak_lvl))
            next_key = 1'b1;
         if (key_down && 20 * 64'(env_lvl) < 7 * 64'(peak_lvl))
            next_key = 1'b0;
         if (next_key != key_down) begin
            // the sample that flips the key is not counted in either run
            judge_run(key_down, run_cnt);
            key_down = next_key;
            run_cnt = '0;
         end else begin
            if (run_cnt != RUN_LIMIT)
               run_cnt++;
            if (!key_down && (64'(run_cnt) << 8) > 10 * 64'(dot_est)) begin
               close_letter();
               close_word();
            end
         end
      end
      if (step_symbols.size() > 0)
         step_symbols[step_symbols.size() - 1].last = 1'b1;
      foreach (step_symbols[i])
         expected_symbols.push_back(step_symbols[i]);
   endfunction

   function automatic void flag_mismatch(string field, logic [31:0] expv, logic [31:0] actv);
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, expv, actv);
      mismatches++;
   endfunction

   // Sender: hold an item until its transfer, idle in random bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_stall = 0;
      end else begin
         if (req_tvalid && req_tready)
            decode_item(offered);
         if (!req_tvalid || req_tready) begin
            if (send_stall == 0 && idle_en && audio_backlog.size() > 0 &&
                $urandom_range(0, 15) == 0)
               send_stall = $urandom_range(1, 19);
            if (send_stall > 0) begin
               send_stall--;
               req_tvalid <= 1'b0;
            end else if (audio_backlog.size() > 0) begin
               offered = audio_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= offered.kind;
               req_tdata <= offered.sample;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each result transfer against the oldest expected symbol
   always @(posedge clock) begin : result_check
      symbol_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_symbols.size() == 0) begin
               $display("%0t: result with nothing expected: expected none, actual %0h/%0h/%0h",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_tuser !== want.kind)
                  flag_mismatch("result_kind", want.kind, rsp_tuser);
               if (rsp_tdata[3:0] !== want.count)
                  flag_mismatch("element_count", want.count, rsp_tdata[3:0]);
               if (rsp_tdata[11:4] !== want.pattern)
                  flag_mismatch("pattern", want.pattern, rsp_tdata[11:4]);
               if (rsp_tdata[12] !== want.too_long)
                  flag_mismatch("too_long", want.too_long, rsp_tdata[12]);
               if (rsp_tlast !== want.last)
                  flag_mismatch("last", want.last, rsp_tlast);
            end
         end
         // long hold-off lets the result queue fill and back up the input
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            ready_stall = LONG_HOLD;
         end else if (ready_stall == 0 && idle_en && $urandom_range(0, 15) == 0) begin
            ready_stall = $urandom_range(1, 19);
         end
         if (ready_stall > 0) begin
            ready_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (audio_backlog.size() != 0 || req_tvalid || expected_symbols.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write a register, then read it back
   task automatic csr_set(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
      for (int is_read = 0; is_read < 2; is_read++) begin
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= (is_read == 0);
         csr_paddr <= {index, 2'b00};
         csr_pwdata <= value;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         if (is_read == 0)
            apply_setting(index, value);
         else if (index != CSR_UNUSED && csr_prdata !== current_setting(index))
            flag_mismatch("register readback", current_setting(index), csr_prdata);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end
   endtask

   task automatic configure(int alpha, int decay, int dot);
      wait_idle();
      csr_set(CSR_ENV_ALPHA, alpha);
      csr_set(CSR_PEAK_DECAY, decay);
      csr_set(CSR_INIT_DOT, dot);
   endtask

   function automatic void queue_sample(logic [SAMPLE_W-1:0] value);
      audio_backlog.push_back('{KIND_SAMPLE, value});
      items_queued++;
   endfunction

   function automatic void queue_flush();
      // sample field is don't-care on a flush, so scramble it
      audio_backlog.push_back('{KIND_FLUSH, SAMPLE_W'($urandom)});
      items_queued++;
   endfunction

   function automatic int jitter(int len);
      int n;
      n = len + $urandom_range(0, 2) - 1;
      return (n < 1) ? 1 : n;
   endfunction

   function automatic void queue_tone(int len, int level);
      int mag;
      for (int i = 0; i < len; i++) begin
         mag = level - $urandom_range(0, level / 8);
         queue_sample($urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag));
      end
   endfunction

   function automatic void queue_hush(int len);
      int mag;
      for (int i = 0; i < len; i++) begin
         mag = $urandom_range(0, 300);
         queue_sample($urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag));
      end
   endfunction

   function automatic void queue_noise(int len);
      for (int i = 0; i < len; i++)
         queue_sample(SAMPLE_W'($urandom));
   endfunction

   function automatic void queue_letter(int elems, int unit, int level);
      for (int k = 0; k < elems; k++) begin
         if (k > 0)
            queue_hush(jitter(unit));
         if ($urandom_range(0, 24) == 0) begin
            // mark broken by a one-sample dropout
            queue_tone(unit, level);
            queue_hush(1);
            queue_tone(unit, level);
         end else begin
            queue_tone(jitter($urandom_range(0, 1) ? 3 * unit : unit), level);
         end
      end
   endfunction

   task automatic queue_morse(int goal, int unit, int level);
      int first;
      int pick;
      first = items_queued;
      while (items_queued - first < goal) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            queue_noise($urandom_range(5, 30));
         end else if (pick == 1) begin
            queue_tone(jitter(2 * unit), level);
            queue_flush();
         end else if (pick == 2) begin
            queue_letter($urandom_range(7, 12), unit, level);
         end else begin
            queue_letter($urandom_range(1, 6), unit, level);
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            queue_hush(jitter(3 * unit));
         end else if (pick < 8) begin
            queue_hush(jitter(7 * unit));
         end else if (pick == 8) begin
            queue_hush(12 * unit);
         end else begin
            // glitch spike inside the space
            queue_hush(jitter(2 * unit));
            queue_tone(1, level);
            queue_hush(jitter(2 * unit));
         end
         while (audio_backlog.size() > 200) @(negedge clock);
      end
   endtask

   initial begin
      int directed_items;
      int unit;
      restart_decoder_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full-scale extremes, flush with the key down
      queue_sample(16'h8000);
      queue_sample(16'h7FFF);
      queue_flush();

      // sharpest envelope, slowest peak decay, one-sample dot
      configure(65535, 16777215, 1);
      csr_set(CSR_UNUSED, 32'hFFFF_FFFF);
      queue_sample(16'h8000);
      queue_sample(16'h7FFF);
      queue_hush(3);
      queue_tone(4, 32767);
      queue_sample(16'h0000);
      queue_sample(16'hFFFF);
      queue_sample(16'h0001);
      queue_hush(9);
      queue_tone(1, 32767);
      queue_hush(1);
      queue_tone(2, 32767);
      queue_flush();
      queue_flush();
      directed_items = items_queued;

      configure(65535, 16777215, 3);
      queue_morse(220, 3, 30000);

      configure($urandom_range(30000, 65535), $urandom_range(16600000, 16777000), 2);
      long_hold_request = 1'b1;
      queue_morse(220, 2, $urandom_range(12000, 32767));

      configure(1, 0, 65535);
      queue_noise(60);
      queue_flush();

      // zero dot estimate
      configure(50000, 16700000, 0);
      queue_morse(60, 2, 20000);

      unit = $urandom_range(2, 5);
      configure($urandom_range(20000, 65535), $urandom_range(16650000, 16777215),
                $urandom_range(1, 6));
      queue_morse(300, unit, $urandom_range(8000, 32767));

      wait_idle();
      idle_en = 1'b0;
      unit = $urandom_range(2, 4);
      configure($urandom_range(20000, 65535), $urandom_range(16650000, 16777215), unit);
      do
         queue_morse(50, unit, $urandom_range(8000, 32767));
      while (items_queued - directed_items < RANDOM_GOAL);

      wait_idle();
      if (mismatches == 0)
         $display("adaptive_morse_tone_decoder_test: done, clean");
      else
         $display("adaptive_morse_tone_decoder_test: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("adaptive_morse_tone_decoder_test: done, errors");
      $finish;
   end

endmodule
